>>> rtl/rbst_pkg.sv
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    localparam int NUM_LANES = 2 * NUM_AXES;

    // Per-item side information that travels beside the divider lanes.
    typedef struct packed {
        logic [NUM_LANES-1:0] qneg;   // quotient of the lane is negative
        logic [NUM_AXES-1:0]  dneg;   // direction component is negative
        logic [NUM_AXES-1:0]  dzero;  // direction component is zero
        logic                 ok;     // every zero-direction axis holds the origin
    } side_t;

    // Pipeline advance control shared by all stages.
    typedef struct packed {
        logic en;
    } ctl_t;

endpackage

>>> rtl/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
//
//   channel | handshake             | word
//   --------+-----------------------+-----------------------------------------
//   input   | in_valid / in_stall   | org_*, dir_*, box_min_*, box_max_*
//   output  | out_valid / out_stall | hit
//
// One test is accepted in every cycle in which no result waits at a stalled output.
// Each word passes from input to output through one preparation stage, one
// stage per quotient bit in each of the six divider lanes, three merging
// stages and the output register.
// Reset clears only the valid bits of the pipeline; the data stages are free.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall
// while a result waits.
module ray_box_slab_test #(
    parameter int COORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] org_x,
    input  logic signed [31:0] org_y,
    input  logic signed [31:0] org_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  logic signed [31:0] box_min_x,
    input  logic signed [31:0] box_min_y,
    input  logic signed [31:0] box_min_z,
    input  logic signed [31:0] box_max_x,
    input  logic signed [31:0] box_max_y,
    input  logic signed [31:0] box_max_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit
);
    import rbst_pkg::*;

    // Integer bits of the distance format, clamped to the supported range.
    localparam int CB = (COORD_BITS < 16) ? 16 : ((COORD_BITS > 48) ? 48 : COORD_BITS);
    // Coordinates use at most 32 bits of each field.
    localparam int CW = (CB < 32) ? CB : 32;
    // Numerator magnitude: the coordinate difference scaled by the fraction.
    localparam int NW = CW + FRAC_BITS;
    // Distance width.
    localparam int DW = CB + FRAC_BITS;

    ctl_t ctl;

    logic signed [CW-1:0] org_c [NUM_AXES];
    logic signed [CW-1:0] dir_c [NUM_AXES];
    logic signed [CW-1:0] mn_c  [NUM_AXES];
    logic signed [CW-1:0] mx_c  [NUM_AXES];

    logic [NW-1:0] num_next [NUM_LANES];
    logic [CW-1:0] den_next [NUM_LANES];
    side_t         side_next;

    logic          pre_vld_reg;
    logic [NW-1:0] pre_num_reg [NUM_LANES];
    logic [CW-1:0] pre_den_reg [NUM_LANES];
    side_t         pre_side_reg;

    logic          line_vld_reg  [NW];
    side_t         line_side_reg [NW];
    logic [NW-1:0] quot [NUM_LANES];

    logic                 res_vld, res_ok;
    logic signed [DW-1:0] res_entry, res_exit;

    logic out_vld_reg;
    logic hit_reg;

    assign org_c[0] = org_x[CW-1:0];
    assign org_c[1] = org_y[CW-1:0];
    assign org_c[2] = org_z[CW-1:0];
    assign dir_c[0] = dir_x[CW-1:0];
    assign dir_c[1] = dir_y[CW-1:0];
    assign dir_c[2] = dir_z[CW-1:0];
    assign mn_c[0]  = box_min_x[CW-1:0];
    assign mn_c[1]  = box_min_y[CW-1:0];
    assign mn_c[2]  = box_min_z[CW-1:0];
    assign mx_c[0]  = box_max_x[CW-1:0];
    assign mx_c[1]  = box_max_y[CW-1:0];
    assign mx_c[2]  = box_max_z[CW-1:0];

    // The whole pipeline moves together unless a finished result is held.
    assign ctl.en   = !(out_vld_reg && out_stall);
    assign in_stall = !ctl.en;

    // Preparation: the divider lanes work on magnitudes, the signs travel aside.
    // Lane 2a divides toward the lower corner of axis a, lane 2a+1 toward the upper.
    always_comb
    begin
        logic signed [CW:0] diff;
        logic [CW:0]        dmag;
        logic [CW-1:0]      bnd;
        logic [CW:0]        dabs;
        side_next.ok = 1'b1;
        side_next.qneg = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            side_next.dneg[a]  = dir_c[a][CW-1];
            side_next.dzero[a] = (dir_c[a] == '0);
            if (side_next.dzero[a] && ((org_c[a] < mn_c[a]) || (org_c[a] > mx_c[a])))
                side_next.ok = 1'b0;
            dabs = dir_c[a][CW-1] ? -{dir_c[a][CW-1], dir_c[a]} : {dir_c[a][CW-1], dir_c[a]};
            for (int b = 0; b < 2; b++)
            begin
                bnd  = (b == 0) ? mn_c[a] : mx_c[a];
                diff = $signed({bnd[CW-1], bnd}) - $signed({org_c[a][CW-1], org_c[a]});
                dmag = diff[CW] ? -diff : diff;
                num_next[2*a+b] = {dmag[CW-1:0], {FRAC_BITS{1'b0}}};
                den_next[2*a+b] = dabs[CW-1:0];
                side_next.qneg[2*a+b] = diff[CW] ^ dir_c[a][CW-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
            for (int s = 0; s < NW; s++)
                line_vld_reg[s] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            pre_vld_reg <= in_valid;
            line_vld_reg[0] <= pre_vld_reg;
            for (int s = 1; s < NW; s++)
                line_vld_reg[s] <= line_vld_reg[s-1];
            out_vld_reg <= res_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                pre_num_reg[l] <= num_next[l];
                pre_den_reg[l] <= den_next[l];
            end
            pre_side_reg <= side_next;
            line_side_reg[0] <= pre_side_reg;
            for (int s = 1; s < NW; s++)
                line_side_reg[s] <= line_side_reg[s-1];
            // The ray meets the box only if the final exit lies beyond the entry.
            hit_reg <= res_ok && (res_exit > res_entry);
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        rbst_div_lane #(
            .CW (CW),
            .NW (NW)
        ) u_lane (
            .clk  (clk),
            .ctl  (ctl),
            .num  (pre_num_reg[l]),
            .den  (pre_den_reg[l]),
            .quot (quot[l])
        );
    end

    rbst_merge #(
        .NW (NW),
        .DW (DW)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .vld       (line_vld_reg[NW-1]),
        .side      (line_side_reg[NW-1]),
        .quot      (quot),
        .res_vld   (res_vld),
        .res_ok    (res_ok),
        .res_entry (res_entry),
        .res_exit  (res_exit)
    );

    assign out_valid = out_vld_reg;
    assign hit       = hit_reg;

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |=> out_vld_reg && $stable(hit_reg))
        else $error("held result changed");

    // The input is stalled only while a result waits at the output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_vld_reg && out_stall)
        else $error("input stalled without a held result");

    // A frozen pipeline does not change the valid bit of the word entering the merge stages.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(line_vld_reg[NW-1]))
        else $error("pipeline moved while stalled");

endmodule

>>> rtl/rbst_div_lane.sv
// One pipelined restoring divider lane, one quotient bit per stage.
module rbst_div_lane #(
    parameter int CW = 32,
    parameter int NW = 48
) (
    input  logic           clk,
    input  rbst_pkg::ctl_t ctl,
    input  logic [NW-1:0]  num,
    input  logic [CW-1:0]  den,
    output logic [NW-1:0]  quot
);
    import rbst_pkg::*;

    // The numerator shifts out at the top while quotient bits shift in below.
    logic [NW-1:0] num_reg  [NW];
    logic [CW-1:0] rem_reg  [NW];
    logic [CW-1:0] den_reg  [NW];
    logic [NW-1:0] num_next [NW];
    logic [CW-1:0] rem_next [NW];
    logic [CW-1:0] den_next [NW];

    always_comb
    begin
        logic [NW-1:0] pn;
        logic [CW-1:0] pr;
        logic [CW-1:0] pd;
        logic [CW:0]   trial;
        logic [CW:0]   diff;
        logic          ge;
        for (int s = 0; s < NW; s++)
        begin
            if (s == 0)
            begin
                pn = num;
                pr = '0;
                pd = den;
            end
            else
            begin
                pn = num_reg[s-1];
                pr = rem_reg[s-1];
                pd = den_reg[s-1];
            end
            trial = {pr, pn[NW-1]};
            diff  = trial - {1'b0, pd};
            ge    = (trial >= {1'b0, pd});
            rem_next[s] = ge ? diff[CW-1:0] : trial[CW-1:0];
            num_next[s] = {pn[NW-2:0], ge};
            den_next[s] = pd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int s = 0; s < NW; s++)
            begin
                num_reg[s] <= num_next[s];
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quot = num_reg[NW-1];

endmodule

>>> rtl/rbst_merge.sv
// Merging stages: saturate the lane quotients and fold entry and exit distances.
module rbst_merge #(
    parameter int NW = 48,
    parameter int DW = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbst_pkg::ctl_t        ctl,
    input  logic                  vld,
    input  rbst_pkg::side_t       side,
    input  logic [NW-1:0]         quot [rbst_pkg::NUM_LANES],
    output logic                  res_vld,
    output logic                  res_ok,
    output logic signed [DW-1:0]  res_entry,
    output logic signed [DW-1:0]  res_exit
);
    import rbst_pkg::*;

    localparam int XW = ((NW > DW) ? NW : DW) + 1;
    localparam logic [XW-1:0] LIM_NEG = {{(XW-1){1'b0}}, 1'b1} << (DW - 1);
    localparam logic [XW-1:0] LIM_POS = LIM_NEG - {{(XW-1){1'b0}}, 1'b1};
    localparam logic signed [DW-1:0] T_HI = LIM_POS[DW-1:0];

    logic                 a_vld_reg, b_vld_reg, c_vld_reg;
    logic                 a_ok_reg, b_ok_reg, c_ok_reg;
    logic signed [DW-1:0] a_en_reg [NUM_AXES];
    logic signed [DW-1:0] a_ex_reg [NUM_AXES];
    logic signed [DW-1:0] a_en_next [NUM_AXES];
    logic signed [DW-1:0] a_ex_next [NUM_AXES];
    logic signed [DW-1:0] b_en_reg [2];
    logic signed [DW-1:0] b_ex_reg [2];
    logic signed [DW-1:0] b_en_next [2];
    logic signed [DW-1:0] b_ex_next [2];
    logic signed [DW-1:0] c_en_reg, c_ex_reg, c_en_next, c_ex_next;

    // Stage A: signed, saturated distances, swapped by direction sign; a zero-direction axis gets zero to T_HI.
    always_comb
    begin
        logic [XW-1:0]        qx;
        logic [XW-1:0]        mag;
        logic signed [DW-1:0] t [NUM_LANES];
        for (int l = 0; l < NUM_LANES; l++)
        begin
            qx = XW'(quot[l]);
            if (side.qneg[l])
                mag = (qx > LIM_NEG) ? LIM_NEG : qx;
            else
                mag = (qx > LIM_POS) ? LIM_POS : qx;
            t[l] = side.qneg[l] ? -mag[DW-1:0] : mag[DW-1:0];
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (side.dzero[a])
            begin
                a_en_next[a] = '0;
                a_ex_next[a] = T_HI;
            end
            else if (side.dneg[a])
            begin
                a_en_next[a] = t[2*a+1];
                a_ex_next[a] = t[2*a];
            end
            else
            begin
                a_en_next[a] = t[2*a];
                a_ex_next[a] = t[2*a+1];
            end
        end
    end

    // Stage B and C: pairwise maximum of entries and minimum of exits; stage B also clamps the third entry at zero.
    always_comb
    begin
        b_en_next[0] = (a_en_reg[0] > a_en_reg[1]) ? a_en_reg[0] : a_en_reg[1];
        b_en_next[1] = (a_en_reg[2] > 0) ? a_en_reg[2] : '0;
        b_ex_next[0] = (a_ex_reg[0] < a_ex_reg[1]) ? a_ex_reg[0] : a_ex_reg[1];
        b_ex_next[1] = a_ex_reg[2];
        c_en_next    = (b_en_reg[0] > b_en_reg[1]) ? b_en_reg[0] : b_en_reg[1];
        c_ex_next    = (b_ex_reg[0] < b_ex_reg[1]) ? b_ex_reg[0] : b_ex_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            a_vld_reg <= vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            a_ok_reg <= side.ok;
            b_ok_reg <= a_ok_reg;
            c_ok_reg <= b_ok_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                a_en_reg[a] <= a_en_next[a];
                a_ex_reg[a] <= a_ex_next[a];
            end
            for (int i = 0; i < 2; i++)
            begin
                b_en_reg[i] <= b_en_next[i];
                b_ex_reg[i] <= b_ex_next[i];
            end
            c_en_reg <= c_en_next;
            c_ex_reg <= c_ex_next;
        end
    end

    assign res_vld   = c_vld_reg;
    assign res_ok    = c_ok_reg;
    assign res_entry = c_en_reg;
    assign res_exit  = c_ex_reg;

endmodule
